FILE: rtl/htf_pkg.sv
// ----------------------------------------------------------------------------
// htf_pkg: shared constants for the html to text filter
// Character codes and the named-entity table used by the decoder.
// ----------------------------------------------------------------------------
package htf_pkg;

   // default size of the entity window ('&' plus name bytes)
   localparam int ENTITY_WINDOW_DEF = 10;

   // character codes
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;

   // named entities: amp, lt, gt, quot, apos, nbsp
   localparam int ENT_NUM = 6;

   // name bytes, first character in the lowest byte
   localparam logic [31:0] ENT_NAME [ENT_NUM] = '{
      32'h0070_6D61,   // amp
      32'h0000_746C,   // lt
      32'h0000_7467,   // gt
      32'h746F_7571,   // quot
      32'h736F_7061,   // apos
      32'h7073_626E    // nbsp
   };

   localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4};

   localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{
      CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SP
   };

endpackage

FILE: rtl/html_to_text_filter_core.sv
// Operation: a word is taken in ST_IDLE; the entity decoder then scans queued bytes
//   in ST_DECODE (rescans after a failed entity go over each held byte again),
//   ST_FLUSH empties the window at end of text, and ST_FINISH closes the run;
//   a stalled result side holds the sequencer.
// Throughput: the decode sequencer works one byte per cycle over the shared window
//   buffer unless the result side stalls; req_tready is low until the word is done.
// Reset: synchronous, active high; clears tag, space and window state.
// ----------------------------------------------------------------------------
// html_to_text_filter_core
// Strips tags, folds white space and decodes entities in a byte stream.
// ----------------------------------------------------------------------------
module html_to_text_filter_core #(
   parameter int ENTITY_WINDOW = htf_pkg::ENTITY_WINDOW_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_text
   // result words
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] text_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] stream_end
   output logic       rsp_tlast    // run_end
);
   import htf_pkg::*;

   localparam int WIN    = ENTITY_WINDOW;
   localparam int DEPTH  = WIN + 1;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(WIN + 1);
   localparam int QCNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // wrap a buffer position that may run past the end once
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] v);
      logic [IDX_W:0] r;
      begin
         r = (v >= (IDX_W+1)'(DEPTH)) ? v - (IDX_W+1)'(DEPTH) : v;
         return r[IDX_W-1:0];
      end
   endfunction

   // circular buffer: entity window followed by bytes waiting to be scanned
   logic [7:0]        buf_ff [DEPTH];

   state_type         state_ff, state_in;
   logic              inside_tag_ff, inside_tag_in;
   logic              last_space_ff, last_space_in;
   logic              amp_ff, amp_in;
   logic              hash_ff, hash_in;
   logic [ENT_NUM-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  wcnt_ff, wcnt_in;
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in;
   logic              end_ff, end_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [7:0]        pend_data_ff, pend_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_bv_ff, rsp_bv_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_send_ff, rsp_send_in;

   logic              buf_we;
   logic [IDX_W-1:0]  buf_wa;
   logic [7:0]        buf_wd;

   logic [IDX_W-1:0]  pos;
   logic [IDX_W-1:0]  rd_addr;
   logic [7:0]        rd_byte;
   logic              can_push;
   logic              emit_req;
   logic              go;
   logic [CNT_W-1:0]  n_name;
   logic              ent_hit;
   logic [7:0]        ent_char_sel;
   logic [ENT_NUM-1:0] mask_app;
   logic              fs_have;
   logic [7:0]        fs_char;
   logic              fs_inside;
   logic              fs_dec;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_send_ff, rsp_bv_ff};
   assign rsp_tlast  = rsp_last_ff;

   // buffer addressing: next unscanned byte sits right after the window
   assign pos      = wrap_idx({1'b0, start_ff} + (IDX_W+1)'(wcnt_ff));
   assign rd_addr  = (state_ff == ST_FLUSH) ? start_ff : pos;
   assign rd_byte  = buf_ff[rd_addr];
   assign can_push = !rsp_valid_ff || rsp_tready;

   // tag stripping and white space folding
   always_comb begin
      fs_have   = 1'b0;
      fs_char   = req_tdata;
      fs_inside = inside_tag_ff;
      if (req_tdata == CH_LT) begin
         fs_inside = 1'b1;
      end else if (req_tdata == CH_GT) begin
         fs_inside = 1'b0;
         fs_have   = 1'b1;
         fs_char   = CH_SP;
      end else if (!inside_tag_ff) begin
         fs_have = 1'b1;
         if (req_tdata == CH_CR || req_tdata == CH_LF || req_tdata == CH_TAB) begin
            fs_char = CH_SP;
         end
      end
      fs_dec = fs_have && !(fs_char == CH_SP && last_space_ff);
   end

   // entity name match, tracked one byte at a time as the name grows
   assign n_name = wcnt_ff - 1'b1;

   always_comb begin
      ent_hit      = 1'b0;
      ent_char_sel = CH_SP;
      for (int k = 0; k < ENT_NUM; k++) begin
         mask_app[k] = mask_ff[k] && (n_name < CNT_W'(ENT_LEN[k])) &&
                       (ENT_NAME[k][{n_name[1:0], 3'b000} +: 8] == rd_byte);
         if (mask_ff[k] && (n_name == CNT_W'(ENT_LEN[k]))) begin
            ent_hit      = 1'b1;
            ent_char_sel = ENT_CHAR[k];
         end
      end
   end

   // does this cycle produce a byte, and may it proceed
   always_comb begin
      emit_req = 1'b0;
      case (state_ff)
         ST_DECODE: begin
            if (amp_ff) begin
               emit_req = !(rd_byte != CH_SEMI && wcnt_ff < CNT_W'(WIN));
            end else begin
               emit_req = (rd_byte != CH_AMP);
            end
         end
         ST_FLUSH: emit_req = (wcnt_ff != '0);
         default:  emit_req = 1'b0;
      endcase
      go = !(emit_req && pend_valid_ff && !can_push);
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      inside_tag_in = inside_tag_ff;
      last_space_in = last_space_ff;
      amp_in        = amp_ff;
      hash_in       = hash_ff;
      mask_in       = mask_ff;
      start_in      = start_ff;
      wcnt_in       = wcnt_ff;
      qcnt_in       = qcnt_ff;
      end_in        = end_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_send_in   = rsp_send_ff;
      buf_we        = 1'b0;
      buf_wa        = pos;
      buf_wd        = fs_char;

      // output register drains
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               inside_tag_in = fs_inside;
               end_in        = req_tlast;
               if (fs_have) begin
                  last_space_in = (fs_char == CH_SP);
               end
               if (fs_dec) begin
                  buf_we   = 1'b1;
                  qcnt_in  = QCNT_W'(1);
                  state_in = ST_DECODE;
               end else begin
                  state_in = req_tlast ? ST_FLUSH : ST_FINISH;
               end
            end
         end

         ST_DECODE: begin
            if (go) begin
               if (!amp_ff) begin
                  qcnt_in = qcnt_ff - 1'b1;
                  if (rd_byte == CH_AMP) begin
                     // open a window
                     amp_in  = 1'b1;
                     wcnt_in = CNT_W'(1);
                     mask_in = '1;
                     hash_in = 1'b0;
                  end else begin
                     pend_data_in = rd_byte;
                     start_in     = wrap_idx({1'b0, start_ff} + (IDX_W+1)'(1));
                  end
               end else if (rd_byte == CH_SEMI && (ent_hit || hash_ff)) begin
                  // entity decoded, window released
                  qcnt_in      = qcnt_ff - 1'b1;
                  pend_data_in = ent_hit ? ent_char_sel : CH_SP;
                  start_in     = wrap_idx({1'b0, start_ff} + (IDX_W+1)'(wcnt_ff) +
                                          (IDX_W+1)'(1));
                  wcnt_in      = '0;
                  amp_in       = 1'b0;
               end else if (rd_byte != CH_SEMI && wcnt_ff < CNT_W'(WIN)) begin
                  // name byte joins the window
                  qcnt_in = qcnt_ff - 1'b1;
                  wcnt_in = wcnt_ff + 1'b1;
                  mask_in = mask_app;
                  if (wcnt_ff == CNT_W'(1)) begin
                     hash_in = (rd_byte == CH_HASH);
                  end
               end else begin
                  // no entity: give the '&' and rescan everything after it
                  pend_data_in = CH_AMP;
                  start_in     = wrap_idx({1'b0, start_ff} + (IDX_W+1)'(1));
                  qcnt_in      = qcnt_ff + QCNT_W'(wcnt_ff) - 1'b1;
                  wcnt_in      = '0;
                  amp_in       = 1'b0;
               end
               if (qcnt_in == '0) begin
                  state_in = end_ff ? ST_FLUSH : ST_FINISH;
               end
            end
         end

         ST_FLUSH: begin
            if (wcnt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (go) begin
               pend_data_in = rd_byte;
               start_in     = wrap_idx({1'b0, start_ff} + (IDX_W+1)'(1));
               wcnt_in      = wcnt_ff - 1'b1;
            end
         end

         ST_FINISH: begin
            if (pend_valid_ff || end_ff) begin
               if (can_push) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = pend_valid_ff ? pend_data_ff : 8'h00;
                  rsp_bv_in     = pend_valid_ff;
                  rsp_last_in   = 1'b1;
                  rsp_send_in   = end_ff;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
                  if (end_ff) begin
                     inside_tag_in = 1'b0;
                     last_space_in = 1'b0;
                     amp_in        = 1'b0;
                     hash_in       = 1'b0;
                     mask_in       = '0;
                     wcnt_in       = '0;
                     end_in        = 1'b0;
                  end
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // a new byte pushes the held one out, which is then not the last
      if (go && emit_req) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pend_data_ff;
            rsp_bv_in    = 1'b1;
            rsp_last_in  = 1'b0;
            rsp_send_in  = 1'b0;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inside_tag_ff <= 1'b0;
         last_space_ff <= 1'b0;
         amp_ff        <= 1'b0;
         hash_ff       <= 1'b0;
         mask_ff       <= '0;
         start_ff      <= '0;
         wcnt_ff       <= '0;
         qcnt_ff       <= '0;
         end_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inside_tag_ff <= inside_tag_in;
         last_space_ff <= last_space_in;
         amp_ff        <= amp_in;
         hash_ff       <= hash_in;
         mask_ff       <= mask_in;
         start_ff      <= start_in;
         wcnt_ff       <= wcnt_in;
         qcnt_ff       <= qcnt_in;
         end_ff        <= end_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_send_ff  <= rsp_send_in;
      if (buf_we) begin
         buf_ff[buf_wa] <= buf_wd;
      end
   end

endmodule

FILE: rtl/htf_checker.sv
// ----------------------------------------------------------------------------
// htf_checker
// Port-level checks on the html to text filter, bound to the top level.
// ----------------------------------------------------------------------------
module htf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // end of text always closes the run of the input word
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("stream end without run end");

   // an empty word is only the end marker and carries zero
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] && rsp_tlast && rsp_tdata == 8'h00)
      else $error("empty word that is not a clean end marker");

   // one input word at a time: busy right after a word is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again without processing");

endmodule

bind html_to_text_filter_core htf_checker u_htf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
